// File: design/chunked_packet_framer_core_assert.svh
// Assertion macros for the chunked packet framer.
// Used by the port checker; no other dependencies.
`ifndef CHUNKED_PACKET_FRAMER_CORE_ASSERT_SVH
`define CHUNKED_PACKET_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cpf_pkg.sv
// Shared types and constants for the chunked packet framer.
// No dependencies.
package cpf_pkg;

    localparam int unsigned MAX_CHUNK_DEF = 256;

    localparam int unsigned POS_CHECKSUM = 0;
    localparam int unsigned POS_ADDRESS  = 1;
    localparam int unsigned POS_LENGTH   = 2;
    localparam int unsigned HEADER_BYTES = 3;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_GIVEN    = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic {
        FR_IDLE,
        FR_READ
    } fr_state_t;

endpackage

// File: design/cpf_in_if.sv
// Request channel of the chunked packet framer: valid/ready plus payload.
// Depends on nothing.
interface cpf_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output mode, output data_byte, output end_of_data,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input end_of_data,
                    output ready);
endinterface

// File: design/cpf_out_if.sv
// Response channel of the chunked packet framer: valid/ready plus payload.
// Depends on cpf_pkg for the status type.
interface cpf_out_if;
    logic             valid;
    logic             ready;
    cpf_pkg::status_t status;
    logic [7:0]       framed_byte;
    logic             packet_end;

    modport source (output valid, output status, output framed_byte, output packet_end,
                    input ready);
    modport sink   (input valid, input status, input framed_byte, input packet_end,
                    output ready);
endinterface

// File: design/cpf_chunk_ram.sv
// Chunk buffer: one write port, one read port with registered read data.
// No dependencies.
module cpf_chunk_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: design/chunked_packet_framer_core.sv
// Top level of the chunked packet framer.
// Depends on cpf_pkg, cpf_in_if, cpf_out_if and cpf_chunk_ram.
//
// Usage:
//   request  : valid/ready channel; mode 0 loads data_byte into the chunk
//              buffer (end_of_data closes the chunk), mode 1 fetches the next
//              framed byte: checksum, address, length, then the data bytes.
//   response : one result per request: status, framed_byte, packet_end.
//   wr_en/wr_data : writes packet_address; write only while idle.
// Timing: a response is valid the cycle after the request is accepted, except
//   for a fetch of a data byte, which goes through the registered buffer read
//   and the FR_READ state before the response register is loaded.
// Throughput: one request per cycle for loads, header fetches and status
//   answers while the response register is empty or draining; data fetches
//   block new requests during FR_READ, as the chunk buffer read is registered.
// Reset: the chunk is empty and open, packet_address is 0, the response
//   register is empty. The buffer contents are not cleared.
// Stall: the response register holds its value while ready is low; a new
//   request is taken only when that register is empty or draining.
module chunked_packet_framer_core #(
    parameter int unsigned MAX_CHUNK = cpf_pkg::MAX_CHUNK_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cpf_in_if.sink      request,
    cpf_out_if.source   response,
    input  logic        wr_en,
    input  logic [7:0]  wr_data
);
    import cpf_pkg::*;

    localparam int unsigned CW = $clog2(MAX_CHUNK + 1);
    localparam int unsigned PW = $clog2(MAX_CHUNK + 3);
    localparam int unsigned AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;

    fr_state_t     state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [7:0]    sum_reg, sum_next;
    logic          closed_reg, closed_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    addr_reg;
    logic          rd_end_reg, rd_end_next;

    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_end_reg, out_end_next;
    logic          out_load;

    logic          accept;
    logic [CW-1:0] fill_inc;
    logic [7:0]    len_byte;
    logic [7:0]    checksum;
    logic [PW-1:0] final_pos;
    logic [PW-1:0] data_idx;
    logic          is_last;

    logic          mem_wr_en;
    logic          mem_rd_en;
    logic [7:0]    mem_rd_data;

    assign request.ready = (state_reg == FR_IDLE) && (!out_valid_reg || response.ready);
    assign accept        = request.valid && request.ready;

    assign fill_inc  = fill_reg + CW'(1);
    assign len_byte  = 8'(fill_reg);
    assign checksum  = 8'd0 - 8'(addr_reg + len_byte + sum_reg);
    assign final_pos = PW'(fill_reg) + PW'(HEADER_BYTES - 1);
    assign data_idx  = pos_reg - PW'(HEADER_BYTES);
    assign is_last   = (pos_reg >= final_pos);

    cpf_chunk_ram #(
        .DEPTH (MAX_CHUNK),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (request.data_byte),
        .rd_en   (mem_rd_en),
        .rd_addr (data_idx[AW-1:0]),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        closed_next     = closed_reg;
        pos_next        = pos_reg;
        rd_end_next     = rd_end_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_end_next    = out_end_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;

        unique case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    out_load      = 1'b1;
                    out_byte_next = 8'd0;
                    out_end_next  = 1'b0;
                    if (!request.mode)
                    begin
                        if (closed_reg)
                        begin
                            out_status_next = ST_REJECTED;
                        end
                        else
                        begin
                            out_status_next = ST_ACCEPTED;
                            mem_wr_en       = 1'b1;
                            fill_next       = fill_inc;
                            sum_next        = sum_reg + request.data_byte;
                            if ((fill_inc >= CW'(MAX_CHUNK)) || request.end_of_data)
                            begin
                                closed_next = 1'b1;
                                pos_next    = '0;
                            end
                        end
                    end
                    else if (!closed_reg)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_status_next = ST_GIVEN;
                        out_end_next    = is_last;
                        priority if (pos_reg == PW'(POS_CHECKSUM))
                        begin
                            out_byte_next = checksum;
                        end
                        else if (pos_reg == PW'(POS_ADDRESS))
                        begin
                            out_byte_next = addr_reg;
                        end
                        else if (pos_reg == PW'(POS_LENGTH))
                        begin
                            out_byte_next = len_byte;
                        end
                        else
                        begin
                            // hold the response until the buffer read returns
                            out_load    = 1'b0;
                            mem_rd_en   = 1'b1;
                            rd_end_next = is_last;
                            state_next  = FR_READ;
                        end
                        if (is_last)
                        begin
                            fill_next   = '0;
                            sum_next    = 8'd0;
                            closed_next = 1'b0;
                            pos_next    = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + PW'(1);
                        end
                    end
                end
            end
            FR_READ:
            begin
                out_load        = 1'b1;
                out_status_next = ST_GIVEN;
                out_byte_next   = mem_rd_data;
                out_end_next    = rd_end_reg;
                state_next      = FR_IDLE;
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FR_IDLE;
            fill_reg      <= '0;
            sum_reg       <= 8'd0;
            closed_reg    <= 1'b0;
            pos_reg       <= '0;
            addr_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            closed_reg    <= closed_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                addr_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_end_reg     <= rd_end_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_end_reg    <= out_end_next;
    end

    assign response.valid       = out_valid_reg;
    assign response.status      = out_status_reg;
    assign response.framed_byte = out_byte_reg;
    assign response.packet_end  = out_end_reg;
endmodule

// File: design/cpf_checker.sv
// Port checker for the chunked packet framer, bound to the top level.
// Depends on cpf_pkg and chunked_packet_framer_core_assert.svh.
`include "chunked_packet_framer_core_assert.svh"

module cpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_mode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_status,
    input logic [7:0] out_byte,
    input logic       out_end
);
    import cpf_pkg::*;

    `CPF_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_status), "stalled response changed")
    `CPF_ASSERT_NOW(a_idle_byte_zero, out_valid && (out_status != ST_GIVEN), (out_byte == 8'd0) && !out_end, "non-data response carries a byte")
    `CPF_ASSERT_NOW(a_end_on_given, out_valid && out_end, out_status == ST_GIVEN, "packet end without a framed byte")
    `CPF_ASSERT_NEXT(a_load_answer, in_valid && in_ready && !in_mode, out_valid && ((out_status == ST_ACCEPTED) || (out_status == ST_REJECTED)), "load not answered next cycle")
endmodule

bind chunked_packet_framer_core cpf_checker u_cpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .in_mode    (request.mode),
    .out_valid  (response.valid),
    .out_ready  (response.ready),
    .out_status (response.status),
    .out_byte   (response.framed_byte),
    .out_end    (response.packet_end)
);

// File: tb/chunked_packet_framer_core_tb.sv
// Self-checking bench for chunked_packet_framer_core: directed and random load/fetch
// traffic with a per-request framing predictor and an in-order response scoreboard.
// Depends on cpf_pkg, cpf_in_if, cpf_out_if and the framer RTL.
module chunked_packet_framer_core_tb;
    import cpf_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned QUIET_START  = 1500;
    localparam int unsigned QUIET_END    = 2500;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       end_of_data;
    } byte_req_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] framed_byte;
        logic       packet_end;
    } frame_resp_t;

    logic       clk;
    logic       rst_n;
    logic       wr_en;
    logic [7:0] wr_data;

    cpf_in_if  req_ch();
    cpf_out_if resp_ch();

    logic [7:0] chunk_buf [256];
    logic [8:0] chunk_len;
    logic [7:0] byte_sum;
    logic       chunk_sealed;
    logic [8:0] send_idx;
    logic [7:0] pkt_addr;

    byte_req_t   requests_pending [$];
    frame_resp_t frames_due [$];

    logic        req_fired = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;
    int unsigned hold_left = 0;
    int unsigned holds_done = 0;
    int unsigned random_count = 0;

    chunked_packet_framer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (resp_ch),
        .wr_en    (wr_en),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic frame_resp_t frame_step(input byte_req_t item);
        frame_resp_t r;
        logic [8:0]  last_idx;
        logic [8:0]  data_idx;
        logic [7:0]  len_byte;
        r.status      = ST_ACCEPTED;
        r.framed_byte = 8'h00;
        r.packet_end  = 1'b0;
        if (!item.mode)
        begin
            if (chunk_sealed)
                r.status = ST_REJECTED;
            else
            begin
                chunk_buf[chunk_len[7:0]] = item.data_byte;
                chunk_len = chunk_len + 9'd1;
                byte_sum  = byte_sum + item.data_byte;
                if (chunk_len >= MAX_CHUNK_DEF || item.end_of_data)
                begin
                    chunk_sealed = 1'b1;
                    send_idx     = 9'd0;
                end
            end
        end
        else if (!chunk_sealed)
            r.status = ST_EMPTY;
        else
        begin
            len_byte = chunk_len[7:0];
            last_idx = chunk_len + 9'(HEADER_BYTES) - 9'd1;
            data_idx = send_idx - 9'(HEADER_BYTES);
            r.status = ST_GIVEN;
            if (send_idx == POS_CHECKSUM)
                r.framed_byte = 8'd0 - (pkt_addr + len_byte + byte_sum);
            else if (send_idx == POS_ADDRESS)
                r.framed_byte = pkt_addr;
            else if (send_idx == POS_LENGTH)
                r.framed_byte = len_byte;
            else
                r.framed_byte = chunk_buf[data_idx[7:0]];
            r.packet_end = (send_idx >= last_idx);
            if (r.packet_end)
            begin
                chunk_len    = 9'd0;
                byte_sum     = 8'd0;
                chunk_sealed = 1'b0;
                send_idx     = 9'd0;
            end
            else
                send_idx = send_idx + 9'd1;
        end
        return r;
    endfunction

    function automatic logic idle_roll();
        return ($urandom_range(99) < 7) && !(cycle_count >= QUIET_START && cycle_count < QUIET_END);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        frame_resp_t got;
        frame_resp_t want;
        if (!rst_n)
        begin
            chunk_len    = 9'd0;
            byte_sum     = 8'd0;
            chunk_sealed = 1'b0;
            send_idx     = 9'd0;
            req_fired   <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            req_fired   <= req_ch.valid && req_ch.ready;
            if (resp_ch.valid && resp_ch.ready)
            begin
                got.status      = resp_ch.status;
                got.framed_byte = resp_ch.framed_byte;
                got.packet_end  = resp_ch.packet_end;
                results_seen <= results_seen + 1;
                if (frames_due.size() == 0)
                begin
                    $display("%0t unexpected response: status %0d byte %02h end %0b", $time,
                             got.status, got.framed_byte, got.packet_end);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t status: expected %0d, got %0d", $time,
                                 want.status, got.status);
                        error_count = error_count + 1;
                    end
                    if (got.framed_byte !== want.framed_byte)
                    begin
                        $display("%0t framed_byte: expected %02h, got %02h", $time,
                                 want.framed_byte, got.framed_byte);
                        error_count = error_count + 1;
                    end
                    if (got.packet_end !== want.packet_end)
                    begin
                        $display("%0t packet_end: expected %0b, got %0b", $time,
                                 want.packet_end, got.packet_end);
                        error_count = error_count + 1;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                frames_due.push_back(frame_step('{req_ch.mode, req_ch.data_byte,
                                                  req_ch.end_of_data}));
            if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(negedge clk)
    begin : request_driver
        byte_req_t nxt;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fired)
        begin
            if (requests_pending.size() != 0 && !idle_roll())
            begin
                nxt = requests_pending.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.mode        <= nxt.mode;
                req_ch.data_byte   <= nxt.data_byte;
                req_ch.end_of_data <= nxt.end_of_data;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // hold off twice with more than 16 requests still queued so the framer backs up
    always @(negedge clk)
    begin : response_receiver
        if (!rst_n)
            resp_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            resp_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 300 : 1200) &&
                 requests_pending.size() > 16)
        begin
            resp_ch.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_done    <= holds_done + 1;
        end
        else
            resp_ch.ready <= !idle_roll();
    end

    task automatic queue_load(input logic [7:0] value, input logic last);
        requests_pending.push_back('{1'b0, value, last});
    endtask

    task automatic queue_fetch();
        requests_pending.push_back('{1'b1, 8'($urandom), 1'($urandom)});
    endtask

    task automatic settle();
        while (requests_pending.size() != 0 || req_ch.valid || frames_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_address(input logic [7:0] value);
        @(negedge clk);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(negedge clk);
        wr_en   <= 1'b0;
        pkt_addr = value;
    endtask

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(59);
        if (r == 0)
            return MAX_CHUNK_DEF;
        if (r == 1)
            return MAX_CHUNK_DEF - 1;
        return $urandom_range(1, 12);
    endfunction

    // a broken packet drops its end mark and its fetches, so it merges into the next one
    task automatic queue_packet(input int unsigned n);
        logic        broken;
        logic        last;
        broken = ($urandom_range(11) == 0);
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                queue_fetch();
            if (broken || i != n - 1)
                last = 1'b0;
            else if (n == MAX_CHUNK_DEF)
                last = 1'($urandom);
            else
                last = 1'b1;
            queue_load(8'($urandom), last);
            random_count++;
        end
        if (!broken)
        begin
            for (int unsigned j = 0; j < n + HEADER_BYTES; j++)
            begin
                if ($urandom_range(19) == 0)
                    queue_load(8'($urandom), 1'($urandom));
                queue_fetch();
                random_count++;
            end
        end
        if ($urandom_range(9) == 0)
            queue_fetch();
    endtask

    initial
    begin : stimulus
        int unsigned npk;
        logic [7:0]  next_addr;
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_data             = 8'h00;
        req_ch.valid        = 1'b0;
        req_ch.mode         = 1'b0;
        req_ch.data_byte    = 8'h00;
        req_ch.end_of_data  = 1'b0;
        resp_ch.ready       = 1'b0;
        pkt_addr            = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_fetch();
        queue_load(8'h00, 1'b0);
        queue_load(8'hFF, 1'b1);
        queue_load(8'h5A, 1'b1);
        queue_fetch();
        queue_fetch();
        settle();
        // change the address between header bytes of one packet
        write_address(8'hFF);
        repeat (4) queue_fetch();
        queue_load(8'hA5, 1'b1);
        repeat (4) queue_fetch();
        settle();
        write_address(8'h00);

        queue_packet(MAX_CHUNK_DEF);
        while (random_count < RANDOM_ITEMS)
        begin
            npk = $urandom_range(3, 8);
            repeat (npk) queue_packet(pick_size());
            settle();
            case ($urandom_range(3))
                0:       next_addr = 8'h00;
                1:       next_addr = 8'hFF;
                default: next_addr = 8'($urandom);
            endcase
            write_address(next_addr);
        end

        settle();
        repeat (8) @(posedge clk);
        if (error_count == 0 && frames_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
